### rtl/core/tlb_lookup_with_lru_fill_macros.svh
// Assertion macros used by the translation buffer port checker.
`ifndef TLB_LOOKUP_WITH_LRU_FILL_MACROS_SVH
`define TLB_LOOKUP_WITH_LRU_FILL_MACROS_SVH
// Same-cycle implication, clocked on clk, off during rst.
`define TLBL_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |-> (c)) else $error("tlbl assertion failed");
// Next-cycle implication, clocked on clk, off during rst.
`define TLBL_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (c)) else $error("tlbl assertion failed");
`endif

### rtl/core/tlbl_pkg.sv
// Shared types and constants of the translation buffer.
`default_nettype none
package tlbl_pkg;
  localparam int PAGE_W  = 32;
  localparam int FRAME_W = 31;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 7;
  localparam int STAMP_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMP, ST_SEL, ST_ROT, ST_PICK, ST_UPD
  } state_t;

  typedef struct packed {
    logic load_ring;
    logic shift;
    logic wr_stamp;
    logic wr_entry;
  } cell_ctrl_t;
endpackage
`default_nettype wire

### rtl/core/tlbl_ifs.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface tlbl_req_if;
  import tlbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [PAGE_W-1:0]    page_number;
  logic [FRAME_W-1:0]   frame_number;
  modport source(output valid, action, page_number, frame_number, input ready);
  modport sink(input valid, action, page_number, frame_number, output ready);
endinterface

interface tlbl_rsp_if;
  import tlbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FRAME_W-1:0]   frame_out;
  logic [SLOT_W-1:0]    slot_index;
  modport source(output valid, hit, frame_out, slot_index, input ready);
  modport sink(input valid, hit, frame_out, slot_index, output ready);
endinterface

interface tlbl_cfg_if;
  import tlbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_W-1:0]     entries_in_use;
  modport source(output valid, entries_in_use, input ready);
  modport sink(input valid, entries_in_use, output ready);
endinterface
`default_nettype wire

### rtl/core/tlbl_cell.sv
// One buffer entry: tag, frame, stamp, valid mark and a stage of the rank ring.
`default_nettype none
module tlbl_cell #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tlbl_pkg::cell_ctrl_t          ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]    n,
  input  wire logic [$clog2(DEPTH+1)-1:0]    rank,
  input  wire logic [$clog2(DEPTH)-1:0]      sel_idx,
  input  wire logic [tlbl_pkg::PAGE_W-1:0]   req_page,
  input  wire logic [tlbl_pkg::FRAME_W-1:0]  req_frame,
  input  wire logic [tlbl_pkg::STAMP_W-1:0]  new_stamp,
  input  wire logic [tlbl_pkg::STAMP_W-1:0]  ring_in_stamp,
  input  wire logic                          ring_in_ok,
  output logic [tlbl_pkg::STAMP_W-1:0]       ring_stamp,
  output logic                               ring_ok,
  output logic                               match,
  output logic                               empty,
  output logic                               pick,
  output logic [tlbl_pkg::FRAME_W-1:0]       frame_sel
);
  import tlbl_pkg::*;

  localparam int NW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [NW-1:0] IDX_N = NW'(IDX);
  localparam logic [IW-1:0] IDX_I = IW'(IDX);

  logic [PAGE_W-1:0]  tag;
  logic [FRAME_W-1:0] frame;
  logic [STAMP_W-1:0] stamp;
  logic               valid;
  logic [NW-1:0]      cnt;
  logic               in_range;
  logic               me;

  assign in_range = IDX_N < n;
  assign me       = sel_idx == IDX_I;

  // Valid mark: set on insert, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.wr_entry && me) begin
      valid <= 1'b1;
    end
  end

  // Entry payload and stamp
  always_ff @(posedge clk) begin
    if (ctrl.wr_entry && me) begin
      tag   <= req_page;
      frame <= req_frame;
    end
    if ((ctrl.wr_entry || ctrl.wr_stamp) && me) begin
      stamp <= new_stamp;
    end
  end

  // Register compare flags against the held request
  always_ff @(posedge clk) begin
    match <= valid && in_range && (tag == req_page);
    empty <= !valid && in_range;
  end

  // Rank ring: load own stamp, then count larger stamps as they pass
  always_ff @(posedge clk) begin
    if (ctrl.load_ring) begin
      ring_stamp <= stamp;
      ring_ok    <= in_range;
      cnt        <= '0;
    end else if (ctrl.shift) begin
      if (ring_ok && (ring_stamp > stamp)) begin
        cnt <= cnt + NW'(1);
      end
      ring_stamp <= ring_in_stamp;
      ring_ok    <= ring_in_ok;
    end
  end

  assign pick      = in_range && (cnt == rank);
  assign frame_sel = me ? frame : '0;
endmodule
`default_nettype wire

### rtl/core/tlb_lookup_with_lru_fill.sv
// Lookup or insert into an empty slot: the request passes the compare, select and
// update steps. Full-buffer insert: compare and select, then the stamp ring rotates
// once around all cells to rank stamps, then pick and update.
// One request at a time; a result not taken on rsp holds the update step.
// Synchronous reset clears valid marks and use counter, size in use = 64.
`default_nettype none
module tlb_lookup_with_lru_fill #(
  parameter int DEPTH         = 64,
  parameter int RECENT_WINDOW = 10
) (
  input wire logic clk,
  input wire logic rst,
  tlbl_req_if.sink   req,
  tlbl_rsp_if.source rsp,
  tlbl_cfg_if.sink   cfg
);
  import tlbl_pkg::*;

  localparam int NW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] ROT_LAST = IW'(DEPTH-1);

  state_t             state, state_next;
  cell_ctrl_t         ctrl;
  logic [CFG_W-1:0]   entries_in_use;
  logic [NW-1:0]      n;
  logic [NW-1:0]      rank;
  logic               req_action;
  logic [PAGE_W-1:0]  req_page;
  logic [FRAME_W-1:0] req_frame;
  logic [IW-1:0]      sel_idx;
  logic               sel_hit;
  logic [IW-1:0]      rot_cnt;
  logic [STAMP_W-1:0] use_counter;
  logic [STAMP_W-1:0] new_stamp;
  logic               out_valid;
  logic               out_free;
  logic               accept;
  logic [DEPTH-1:0]   match_v;
  logic [DEPTH-1:0]   empty_v;
  logic [DEPTH-1:0]   pick_v;
  logic [STAMP_W-1:0] ring_s [DEPTH];
  logic               ring_o [DEPTH];
  logic [FRAME_W-1:0] frame_g [DEPTH];
  logic [FRAME_W-1:0] frame_hit;

  function automatic logic [IW-1:0] first_set(input logic [DEPTH-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign new_stamp = use_counter + STAMP_W'(1);
  assign cfg.ready = 1'b1;

  // Size in use, clamped to 1..DEPTH
  always_comb begin
    if (entries_in_use == '0) begin
      n = NW'(1);
    end else if (32'(entries_in_use) > 32'(DEPTH)) begin
      n = NW'(DEPTH);
    end else begin
      n = NW'(entries_in_use);
    end
  end

  // Victim rank: oldest when small, else window-th most recent
  assign rank = (32'(n) <= 32'(RECENT_WINDOW)) ? (n - NW'(1)) : NW'(RECENT_WINDOW - 1);

  // Row of cells, ring closed from last to first
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tlbl_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .n             (n),
      .rank          (rank),
      .sel_idx       (sel_idx),
      .req_page      (req_page),
      .req_frame     (req_frame),
      .new_stamp     (new_stamp),
      .ring_in_stamp (ring_s[(g + DEPTH - 1) % DEPTH]),
      .ring_in_ok    (ring_o[(g + DEPTH - 1) % DEPTH]),
      .ring_stamp    (ring_s[g]),
      .ring_ok       (ring_o[g]),
      .match         (match_v[g]),
      .empty         (empty_v[g]),
      .pick          (pick_v[g]),
      .frame_sel     (frame_g[g])
    );
  end

  // Gather the selected frame
  always_comb begin
    frame_hit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      frame_hit = frame_hit | frame_g[i];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CMP;
      ST_CMP:  state_next = ST_SEL;
      ST_SEL: begin
        if (req_action == ACT_INSERT && !(|empty_v)) state_next = ST_ROT;
        else state_next = ST_UPD;
      end
      ST_ROT:  if (rot_cnt == ROT_LAST) state_next = ST_PICK;
      ST_PICK: state_next = ST_UPD;
      ST_UPD:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready      = state == ST_IDLE;
    ctrl.load_ring = (state == ST_SEL) && (req_action == ACT_INSERT) && !(|empty_v);
    ctrl.shift     = state == ST_ROT;
    ctrl.wr_entry  = (state == ST_UPD) && out_free && (req_action == ACT_INSERT);
    ctrl.wr_stamp  = (state == ST_UPD) && out_free && (req_action == ACT_LOOKUP) && sel_hit;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= CFG_RESET;
      use_counter    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) entries_in_use <= cfg.entries_in_use;
      if (ctrl.wr_entry || ctrl.wr_stamp) use_counter <= new_stamp;
      if (state == ST_UPD && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold request, selection and result
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= req.action;
      req_page   <= req.page_number;
      req_frame  <= req.frame_number;
    end
    case (state)
      ST_SEL: begin
        sel_hit <= (req_action == ACT_LOOKUP) && (|match_v);
        sel_idx <= (req_action == ACT_LOOKUP) ? first_set(match_v) : first_set(empty_v);
        rot_cnt <= '0;
      end
      ST_ROT:  rot_cnt <= rot_cnt + IW'(1);
      ST_PICK: sel_idx <= first_set(pick_v);
      ST_UPD: begin
        if (out_free) begin
          rsp.hit        <= sel_hit;
          rsp.frame_out  <= sel_hit ? frame_hit : '0;
          rsp.slot_index <= (sel_hit || req_action == ACT_INSERT) ? SLOT_W'(sel_idx) : '0;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid = out_valid;
endmodule
`default_nettype wire

### rtl/core/tlbl_chk.sv
// Port checker for the translation buffer and its bind.
`default_nettype none
`include "tlb_lookup_with_lru_fill_macros.svh"
module tlbl_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        rsp_hit,
  input wire logic [30:0] rsp_frame_out
);
  // Result held until taken
  `TLBL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  // One request at a time
  `TLBL_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  // No result in the cycle after a request on an empty output
  `TLBL_ASSERT_NXT(a_no_early_rsp, req_valid && req_ready && !rsp_valid, !rsp_valid)
  // Miss and insert report frame zero
  `TLBL_ASSERT_IMP(a_miss_zero_frame, rsp_valid && !rsp_hit, rsp_frame_out == 31'd0)
endmodule

bind tlb_lookup_with_lru_fill tlbl_chk u_tlbl_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_frame_out (rsp.frame_out)
);
`default_nettype wire
